// ----- rtl/core/seamless_redundancy_dedup_assert.svh -----
// assertion macros for the duplicate filter checker
`ifndef SEAMLESS_REDUNDANCY_DEDUP_ASSERT_SVH
`define SEAMLESS_REDUNDANCY_DEDUP_ASSERT_SVH

// implication in the same cycle, ignored while reset is low
`define SRD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srd assertion failed");

// implication on the next cycle, also checked through reset
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("srd assertion failed");

// next-cycle implication, ignored while reset is low
`define SRD_ASSERT_NEXT_RUN(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srd assertion failed");

`endif

// ----- rtl/core/srd_pkg.sv -----
// shared types and constants of the duplicate filter
`default_nettype none

package srd_pkg;

    localparam int SEQ_W       = 16;
    localparam int LEN_W       = 16;
    localparam int CNT_W       = 32;
    localparam int MARK_WORDS  = 1024;
    localparam int WORD_BITS   = 64;
    localparam int WORD_IDX_W  = $clog2(MARK_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_number;
        logic [LEN_W-1:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic             status;
        logic             dup_flag;
        logic [CNT_W-1:0] packets_total;
        logic [CNT_W-1:0] duplicates_total;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic             is_short;
        logic             do_clear;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] start;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_PUT
    } t_back_state;

endpackage

`default_nettype wire

// ----- rtl/core/srd_front.sv -----
// front part: accepts items, tracks the highest sequence, classifies
`default_nettype none

module srd_front #(
    parameter int CLEAR_WINDOW = 4096,
    parameter int MIN_LENGTH   = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  srd_pkg::t_in_item    i_in_item,
    input  srd_pkg::t_q_status   i_q_status,
    input  wire                  i_init_busy,
    output logic                 o_push,
    output srd_pkg::t_cmd        o_cmd
);
    import srd_pkg::*;

    logic             r_started;
    logic [SEQ_W-1:0] r_highest;

    logic             accept;
    logic             is_short;
    logic [SEQ_W-1:0] diff;
    logic             advance;
    logic [SEQ_W-1:0] n_clear;

    // hold off while the queue is full or the mark store is being cleared
    assign o_in_stall = i_q_status.full || i_init_busy;
    assign accept     = i_in_valid && !o_in_stall;

    // classify the item against the highest sequence so far
    always_comb begin
        is_short = i_in_item.packet_length < LEN_W'(MIN_LENGTH);
        diff     = i_in_item.seq_number - r_highest;
        advance  = r_started && (diff != '0) && !diff[SEQ_W-1];
        n_clear  = (diff > SEQ_W'(CLEAR_WINDOW)) ? SEQ_W'(CLEAR_WINDOW) : diff;
    end

    always_comb begin
        o_push         = accept;
        o_cmd.is_short = is_short;
        o_cmd.do_clear = !is_short && advance;
        o_cmd.seq      = i_in_item.seq_number;
        o_cmd.start    = i_in_item.seq_number - n_clear + SEQ_W'(1);
    end

    // highest sequence tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_highest <= '0;
        end else if (accept && !is_short && (!r_started || advance)) begin
            r_started <= 1'b1;
            r_highest <= i_in_item.seq_number;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/srd_queue.sv -----
// short queue of classified items between front and back
`default_nettype none

module srd_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  srd_pkg::t_cmd        i_cmd,
    input  wire                  i_pop,
    output srd_pkg::t_cmd        o_head,
    output srd_pkg::t_q_status   o_status
);
    import srd_pkg::*;

    t_cmd                 r_entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_head          = r_entries[r_rd_ptr];
    assign o_status.full   = r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign o_status.empty  = r_count == '0;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/srd_back.sv -----
// back part: mark store, window clearing, test and set, counters, output
`default_nettype none

module srd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  srd_pkg::t_q_status   i_q_status,
    input  srd_pkg::t_cmd        i_q_head,
    output logic                 o_q_pop,
    output logic                 o_init_busy,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output srd_pkg::t_out_item   o_out_item
);
    import srd_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [WORD_IDX_W-1:0] r_init_addr;
    t_cmd                  r_cmd;
    logic [WORD_IDX_W-1:0] r_word;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic [WORD_BITS-1:0]  r_mem [MARK_WORDS];
    logic [CNT_W-1:0]      r_pkt_cnt;
    logic [CNT_W-1:0]      r_dup_cnt;
    t_out_item             r_res;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [WORD_IDX_W-1:0] start_word;
    logic [WORD_IDX_W-1:0] end_word;
    logic                  is_first;
    logic                  is_last;
    logic                  is_middle;
    logic [BIT_IDX_W-1:0]  lo_bit;
    logic [BIT_IDX_W-1:0]  hi_bit;
    logic [WORD_BITS-1:0]  clr_mask;
    logic [WORD_BITS-1:0]  cleared;
    logic [WORD_BITS-1:0]  seq_bit;
    logic                  dup;
    logic                  init_last;
    logic                  out_free;

    logic                  mem_we;
    logic [WORD_IDX_W-1:0] mem_wa;
    logic [WORD_BITS-1:0]  mem_wd;
    logic                  mem_re;
    logic                  word_step;
    logic                  wr_last;
    logic                  load_out;

    // window geometry of the current item
    always_comb begin
        start_word = r_cmd.start[SEQ_W-1:BIT_IDX_W];
        end_word   = r_cmd.seq[SEQ_W-1:BIT_IDX_W];
        is_first   = r_word == start_word;
        is_last    = r_word == end_word;
        is_middle  = r_cmd.do_clear && !is_first && !is_last;
        lo_bit     = is_first ? r_cmd.start[BIT_IDX_W-1:0] : '0;
        hi_bit     = is_last ? r_cmd.seq[BIT_IDX_W-1:0] : '1;
        clr_mask   = r_cmd.do_clear ?
                     (({WORD_BITS{1'b1}} << lo_bit) &
                      ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS-1) - hi_bit))) : '0;
        cleared    = r_rd_data & ~clr_mask;
        seq_bit    = WORD_BITS'(1) << r_cmd.seq[BIT_IDX_W-1:0];
        dup        = (cleared & seq_bit) != '0;
        init_last  = r_init_addr == WORD_IDX_W'(MARK_WORDS-1);
        out_free   = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (init_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = i_q_head.is_short ? ST_PUT : ST_RD;
                end
            end
            ST_RD: begin
                if (!is_middle) n_state = ST_WR;
            end
            ST_WR: begin
                n_state = is_last ? ST_PUT : ST_RD;
            end
            ST_PUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // state outputs: memory port, queue pop, word stepping
    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_word;
        mem_wd    = '0;
        mem_re    = 1'b0;
        word_step = 1'b0;
        wr_last   = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_init_addr;
            end
            ST_IDLE: begin
                o_q_pop = !i_q_status.empty;
            end
            ST_RD: begin
                if (is_middle) begin
                    mem_we    = 1'b1;
                    word_step = 1'b1;
                end else begin
                    mem_re = 1'b1;
                end
            end
            ST_WR: begin
                mem_we = 1'b1;
                if (is_last) begin
                    mem_wd  = cleared | seq_bit;
                    wr_last = 1'b1;
                end else begin
                    mem_wd    = cleared;
                    word_step = 1'b1;
                end
            end
            ST_PUT: begin
                load_out = out_free;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    assign o_init_busy = r_state == ST_INIT;

    // mark store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_word];
        end
    end

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_pkt_cnt   <= '0;
            r_dup_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT) begin
                r_init_addr <= r_init_addr + 1'b1;
            end
            if (wr_last) begin
                r_pkt_cnt <= r_pkt_cnt + 1'b1;
                r_dup_cnt <= r_dup_cnt + CNT_W'(dup);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload, pending result and output register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_q_head;
            r_word <= i_q_head.do_clear ? i_q_head.start[SEQ_W-1:BIT_IDX_W]
                                        : i_q_head.seq[SEQ_W-1:BIT_IDX_W];
            r_res.status           <= STATUS_INVALID;
            r_res.dup_flag         <= 1'b0;
            r_res.packets_total    <= r_pkt_cnt;
            r_res.duplicates_total <= r_dup_cnt;
        end else if (word_step) begin
            r_word <= r_word + 1'b1;
        end
        if (wr_last) begin
            r_res.status           <= STATUS_OK;
            r_res.dup_flag         <= dup;
            r_res.packets_total    <= r_pkt_cnt + 1'b1;
            r_res.duplicates_total <= r_dup_cnt + CNT_W'(dup);
        end
        if (load_out) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/core/seamless_redundancy_dedup.sv -----
// top level of the seamless redundancy duplicate filter
// Input channel: one item per packet, sequence number and length, taken at an
// edge where i_in_valid is high and o_in_stall is low. Output channel: one item
// per input item, in order, held in an output register until taken at an edge
// where o_out_valid is high and i_out_stall is low.
// A front part classifies each item against the highest sequence and pushes
// it into a four-entry queue; a back part runs the 1024 x 64 mark store, one
// read and one write port with registered read data.
// Per valid item the back part steps through pop, read, write and output load
// when the clear window stays in the item's own mark word. A jump whose window
// spans k words reads and writes each edge word and clears each inner word with
// a single write. A short packet takes only the pop and the output load steps.
// The back part takes one item at a time; later items wait in the queue.
// After reset the mark store is cleared one word per cycle, with o_in_stall
// held high. A stalled receiver holds the output register;
// the back part then waits with its finished item, and the queue keeps
// taking items until it fills.
`default_nettype none

module seamless_redundancy_dedup #(
    parameter int CLEAR_WINDOW = 4096,
    parameter int MIN_LENGTH   = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  srd_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output srd_pkg::t_out_item   o_out_item
);
    import srd_pkg::*;

    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      q_head;
    logic      push;
    logic      pop;
    logic      init_busy;

    // classify and enqueue
    srd_front #(
        .CLEAR_WINDOW (CLEAR_WINDOW),
        .MIN_LENGTH   (MIN_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_q_status  (q_status),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decoupling queue
    srd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // mark store and result generation
    srd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_head    (q_head),
        .o_q_pop     (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/core/srd_checker.sv -----
// port-level checker for the duplicate filter and its bind
`default_nettype none
`include "seamless_redundancy_dedup_assert.svh"

module srd_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input srd_pkg::t_in_item    i_in_item,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input srd_pkg::t_out_item   o_out_item
);
    import srd_pkg::*;

    logic out_short;

    // a rejected packet on the output
    assign out_short = o_out_valid && (o_out_item.status == STATUS_INVALID);

    // a stalled result stays and holds
    `SRD_ASSERT_NEXT_RUN(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // a rejected packet is never a duplicate
    `SRD_ASSERT_IMPL(a_short_no_dup, out_short, !o_out_item.dup_flag)

    // reset starts the clearing sweep with input held off
    `SRD_ASSERT_NEXT(a_reset_stall, !i_rst_n, o_in_stall)

    // reset leaves no result pending
    `SRD_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_out_valid)

endmodule

bind seamless_redundancy_dedup srd_checker u_srd_checker (.*);

`default_nettype wire

// ----- verif/seamless_redundancy_dedup_tb.sv -----
// testbench for the seamless redundancy duplicate filter with a self-checking predictor
`timescale 1ns / 100ps

module seamless_redundancy_dedup_tb;

    import srd_pkg::*;

    localparam int MIN_LEN     = 12;
    localparam int CLEAR_SPAN  = 4096;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 600000;
    localparam int BURST_ITEMS = 165;
    localparam int BURSTS      = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // items waiting to be offered, verdicts waiting to come out
    t_in_item  packet_backlog[$];
    t_out_item awaited_verdicts[$];
    t_out_item want_verdict;

    // predictor state
    bit               seq_started = 1'b0;
    logic [15:0]      top_seq = '0;
    bit [65535:0]     seen_bits = '0;
    logic [31:0]      valid_count = '0;
    logic [31:0]      dup_count = '0;

    // stimulus shaping
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_start = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;
    logic [15:0] gen_seq = '0;
    int          fault_count = 0;
    int          cycle_count = 0;

    seamless_redundancy_dedup #(
        .CLEAR_WINDOW(CLEAR_SPAN),
        .MIN_LENGTH  (MIN_LEN)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // expected verdict for one packet, updates the predictor state
    function automatic t_out_item filter_packet(input t_in_item pkt);
        t_out_item   res;
        logic [15:0] step;
        int          span;
        res.status   = STATUS_OK;
        res.dup_flag = 1'b0;
        if (pkt.packet_length < MIN_LEN) begin
            // short packet leaves everything alone
            res.status           = STATUS_INVALID;
            res.packets_total    = valid_count;
            res.duplicates_total = dup_count;
            return res;
        end
        valid_count = valid_count + 32'd1;
        if (!seq_started) begin
            seq_started = 1'b1;
            top_seq = pkt.seq_number;
            seen_bits = '0;
            seen_bits[pkt.seq_number] = 1'b1;
        end else begin
            step = pkt.seq_number - top_seq;
            // forward move: clear the window ending at the new sequence
            if (step != 16'd0 && !step[15]) begin
                span = (int'(step) > CLEAR_SPAN) ? CLEAR_SPAN : int'(step);
                for (int i = 0; i < span; i++) begin
                    seen_bits[16'(pkt.seq_number - 16'(i))] = 1'b0;
                end
                top_seq = pkt.seq_number;
            end
            if (seen_bits[pkt.seq_number]) begin
                res.dup_flag = 1'b1;
                dup_count = dup_count + 32'd1;
            end
            seen_bits[pkt.seq_number] = 1'b1;
        end
        res.packets_total    = valid_count;
        res.duplicates_total = dup_count;
        return res;
    endfunction

    task automatic queue_packet(input logic [15:0] s, input logic [15:0] len);
        t_in_item pkt;
        pkt.seq_number    = s;
        pkt.packet_length = len;
        packet_backlog.push_back(pkt);
    endtask

    // mostly an advancing stream seen on two paths, with late, lost and short packets
    task automatic queue_random_burst(input int count);
        int          n;
        int          pick;
        logic [15:0] s;
        logic [15:0] len;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            len  = 16'($urandom_range(65535, MIN_LEN));
            if (pick < 50) begin
                gen_seq = gen_seq + 16'd1;
                s = gen_seq;
            end else if (pick < 66) begin
                s = gen_seq - 16'($urandom_range(150));
            end else if (pick < 74) begin
                gen_seq = gen_seq + 16'($urandom_range(130, 2));
                s = gen_seq;
            end else if (pick < 78) begin
                gen_seq = gen_seq + 16'($urandom_range(32767, 4000));
                s = gen_seq;
            end else if (pick < 81) begin
                s = gen_seq + 16'h8000;
            end else if (pick < 84) begin
                s = 16'($urandom_range(65535));
            end else if (pick < 91) begin
                s = gen_seq - 16'($urandom_range(3));
            end else begin
                // too short, random content
                s = 16'($urandom_range(65535));
                len = 16'($urandom_range(MIN_LEN - 1));
            end
            queue_packet(s, len);
            n++;
            // the same packet again from the redundant path
            if (pick < 50 && $urandom_range(99) < 45) begin
                queue_packet(s, 16'($urandom_range(65535, MIN_LEN)));
                n++;
            end
        end
    endtask

    // sender: offers backlog items, holds them while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                awaited_verdicts.push_back(filter_packet(i_in_item));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (packet_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= packet_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_start != hold_seen) begin
            hold_seen <= hold_start;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: compare each taken verdict with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_verdicts.size() == 0) begin
                $display("%0t unexpected item: expected none, got %h", $time, o_out_item);
                fault_count++;
            end else begin
                want_verdict = awaited_verdicts.pop_front();
                if (o_out_item.status !== want_verdict.status) begin
                    $display("%0t status: expected %0d, got %0d", $time,
                             want_verdict.status, o_out_item.status);
                    fault_count++;
                end
                if (o_out_item.dup_flag !== want_verdict.dup_flag) begin
                    $display("%0t dup_flag: expected %0d, got %0d", $time,
                             want_verdict.dup_flag, o_out_item.dup_flag);
                    fault_count++;
                end
                if (o_out_item.packets_total !== want_verdict.packets_total) begin
                    $display("%0t packets_total: expected %0d, got %0d", $time,
                             want_verdict.packets_total, o_out_item.packets_total);
                    fault_count++;
                end
                if (o_out_item.duplicates_total !== want_verdict.duplicates_total) begin
                    $display("%0t duplicates_total: expected %0d, got %0d", $time,
                             want_verdict.duplicates_total, o_out_item.duplicates_total);
                    fault_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // reset, stimulus and end of run
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short before start, wrap, window edges, half range
        queue_packet(16'd100, 16'd0);
        queue_packet(16'd100, 16'd11);
        queue_packet(16'hFFFF, 16'd12);
        queue_packet(16'hFFFF, 16'hFFFF);
        queue_packet(16'h0000, 16'd100);
        queue_packet(16'hFFFE, 16'd100);
        queue_packet(16'hFFFE, 16'd100);
        queue_packet(16'h0040, 16'd100);
        queue_packet(16'h0010, 16'd100);
        queue_packet(16'h1040, 16'd100);
        queue_packet(16'h0040, 16'd100);
        queue_packet(16'h1040, 16'd100);
        queue_packet(16'h3040, 16'd100);
        queue_packet(16'h3040, 16'd100);
        queue_packet(16'hB040, 16'd100);
        queue_packet(16'hB03F, 16'd100);
        queue_packet(16'hB03F, 16'd11);
        queue_packet(16'hB03F, 16'd100);
        queue_packet(16'h5555, 16'hAAAA);
        queue_packet(16'hAAAA, 16'h5555);
        queue_packet(16'hAAAA, 16'h0000);
        queue_packet(16'hAAAB, 16'd13);
        gen_seq = 16'hAAAB;
        while (packet_backlog.size() != 0) @(posedge i_clk);

        // random bursts under each idling pattern
        for (int p = 0; p < BURSTS; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            queue_random_burst(BURST_ITEMS);
            // back-pressure: receiver holds while the sender keeps offering
            if (p == 4) begin
                hold_start = ~hold_start;
            end
            while (packet_backlog.size() != 0) @(posedge i_clk);
        end

        while (i_in_valid) @(posedge i_clk);
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/srd_pkg.sv
rtl/core/srd_front.sv
rtl/core/srd_queue.sv
rtl/core/srd_back.sv
rtl/core/seamless_redundancy_dedup.sv
rtl/core/srd_checker.sv
verif/seamless_redundancy_dedup_tb.sv
